[rtl/idpr_pkg.sv]
package idpr_pkg;

	localparam int BYTES_PER_ITEM = 4;
	localparam int WORD_BYTES     = 4;
	localparam int PROD_W         = 17;
	localparam int GROUP_W        = 18;
	localparam int QUEUE_DEPTH    = 2;
	localparam int QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TWO_COLUMNS     = 2'd0,
		REG_QUANTIZE_OUTPUT = 2'd1,
		REG_CLAMP_MIN       = 2'd2,
		REG_CLAMP_MAX       = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [31:0]        source_word_a;
		logic [31:0]        source_word_b;
		logic [31:0]        weight_word;
		logic signed [31:0] channel_bias;
		logic signed [31:0] channel_scale;
		logic               last;
	} in_t;

	typedef struct packed {
		logic signed [31:0] result_a;
		logic signed [31:0] result_b;
	} out_t;

	typedef struct packed {
		logic              two_columns;
		logic              quantize_output;
		logic signed [7:0] clamp_min;
		logic signed [7:0] clamp_max;
	} cfg_t;

	// one finished dot product waiting for requantization
	typedef struct packed {
		logic signed [31:0] sum_a;
		logic signed [31:0] sum_b;
		logic signed [31:0] bias;
		logic signed [31:0] scale;
		logic               two_col;
	} job_t;

	typedef struct packed {
		logic full;
		logic valid;
	} q_status_t;

	function automatic logic signed [PROD_W-1:0] lane_prod(
		input logic [31:0] src,
		input logic [31:0] wgt,
		input int          i
	);
		logic signed [PROD_W-1:0] p;
		p = '0;
		if (i < WORD_BYTES) begin
			p = $signed({1'b0, src[8*i +: 8]}) * $signed(wgt[8*i +: 8]);
		end
		return p;
	endfunction

endpackage

[rtl/int8_dot_product_requantize.sv]
// channel  | dir | handshake              | beat
// cfg      | in  | cfg_we                 | cfg_index, cfg_data (8 bit)
// in       | in  | in_valid / in_stall    | in_data: three byte words, bias, scale, last
// out      | out | out_valid / out_stall  | out_data: result_a, result_b
//
// one beat per cycle on the input unless in_stall; products and group sum are
// registered, and the accumulator adds once per beat as the beat leaves that stage.
// a last beat, once taken, goes on through queue hand-over,
// bias add, 32x32 scale multiply, clamp, round and offset into the output register.
// in_stall rises only while a last beat waits for room in the two-entry queue.
// reset clears the accumulators, the queue and all valids; no clearing pass.
module int8_dot_product_requantize (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [idpr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [idpr_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  idpr_pkg::in_t                      in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output idpr_pkg::out_t                     out_data
);
	import idpr_pkg::*;

	cfg_t      cfg_q;
	job_t      push_job;
	job_t      pop_job;
	q_status_t q_status;
	logic      push;
	logic      pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.two_columns     <= 1'b0;
			cfg_q.quantize_output <= 1'b1;
			cfg_q.clamp_min       <= -8'sd128;
			cfg_q.clamp_max       <= 8'sd127;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_TWO_COLUMNS:     cfg_q.two_columns     <= cfg_data[0];
				REG_QUANTIZE_OUTPUT: cfg_q.quantize_output <= cfg_data[0];
				REG_CLAMP_MIN:       cfg_q.clamp_min       <= $signed(cfg_data);
				REG_CLAMP_MAX:       cfg_q.clamp_max       <= $signed(cfg_data);
				default:             cfg_q                 <= cfg_q;
			endcase
		end
	end

	idpr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.two_columns (cfg_q.two_columns),
		.q_full      (q_status.full),
		.push        (push),
		.job         (push_job)
	);

	idpr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.job_in  (push_job),
		.pop     (pop),
		.status  (q_status),
		.job_out (pop_job)
	);

	idpr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_status.valid),
		.job       (pop_job),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

[rtl/idpr_front.sv]
module idpr_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  idpr_pkg::in_t in_data,
	input  logic          two_columns,
	input  logic          q_full,
	output logic          push,
	output idpr_pkg::job_t job
);
	import idpr_pkg::*;

	logic                      valid_s1;
	logic                      last_s1;
	logic                      col_b_s1;
	logic signed [GROUP_W-1:0] group_a_s1;
	logic signed [GROUP_W-1:0] group_b_s1;
	logic signed [31:0]        bias_s1;
	logic signed [31:0]        scale_s1;
	logic signed [31:0]        sum_a_q;
	logic signed [31:0]        sum_b_q;

	logic signed [GROUP_W-1:0] group_a;
	logic signed [GROUP_W-1:0] group_b;
	logic signed [31:0]        new_a;
	logic signed [31:0]        new_b;
	logic                      accept;
	logic                      retire;

	function automatic logic signed [31:0] sat_add(
		input logic signed [31:0]        acc,
		input logic signed [GROUP_W-1:0] grp
	);
		logic signed [32:0] s;
		s = {acc[31], acc} + {{(33-GROUP_W){grp[GROUP_W-1]}}, grp};
		if (s[32] != s[31]) begin
			return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end
		return s[31:0];
	endfunction

	always_comb begin
		group_a = '0;
		group_b = '0;
		for (int i = 0; i < BYTES_PER_ITEM; i++) begin
			group_a = group_a + GROUP_W'(lane_prod(in_data.source_word_a, in_data.weight_word, i));
			group_b = group_b + GROUP_W'(lane_prod(in_data.source_word_b, in_data.weight_word, i));
		end
	end

	// only a last beat can hold the stage, and only while the queue is full
	assign in_stall = valid_s1 && last_s1 && q_full;
	assign accept   = in_valid && !in_stall;
	assign retire   = valid_s1 && (!last_s1 || !q_full);
	assign push     = valid_s1 && last_s1 && !q_full;

	assign new_a = sat_add(sum_a_q, group_a_s1);
	assign new_b = col_b_s1 ? sat_add(sum_b_q, group_b_s1) : sum_b_q;

	assign job.sum_a   = new_a;
	assign job.sum_b   = new_b;
	assign job.bias    = bias_s1;
	assign job.scale   = scale_s1;
	assign job.two_col = col_b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (retire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1    <= in_data.last;
			col_b_s1   <= two_columns;
			group_a_s1 <= group_a;
			group_b_s1 <= group_b;
			bias_s1    <= in_data.channel_bias;
			scale_s1   <= in_data.channel_scale;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_a_q <= '0;
			sum_b_q <= '0;
		end else if (retire) begin
			if (last_s1) begin
				sum_a_q <= '0;
				sum_b_q <= '0;
			end else begin
				sum_a_q <= new_a;
				sum_b_q <= new_b;
			end
		end
	end

`ifndef SYNTHESIS
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		retire && last_s1 |=> sum_a_q == 32'sd0 && sum_b_q == 32'sd0)
		else $error("accumulators not cleared after last beat");
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && last_s1 && !push)
		else $error("input stalled without a held last beat");
`endif

endmodule

[rtl/idpr_queue.sv]
module idpr_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  idpr_pkg::job_t       job_in,
	input  logic                 pop,
	output idpr_pkg::q_status_t  status,
	output idpr_pkg::job_t       job_out
);
	import idpr_pkg::*;

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign status.valid = (count_q != '0);
	assign job_out      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= job_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !status.full)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> status.valid)
		else $error("pop from empty queue");
`endif

endmodule

[rtl/idpr_back.sv]
module idpr_back (
	input  logic           clk,
	input  logic           arst_n,
	input  idpr_pkg::cfg_t cfg,
	input  logic           q_valid,
	input  idpr_pkg::job_t job,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output idpr_pkg::out_t out_data
);
	import idpr_pkg::*;

	logic               valid_s1, valid_s2, valid_s3, valid_q;
	logic               two_col_s1, two_col_s2, two_col_s3;
	logic signed [31:0] d_a_s1, d_b_s1, scale_s1;
	logic signed [31:0] d_a_s2, d_b_s2;
	logic signed [63:0] p_a_s2, p_b_s2;
	logic signed [31:0] v_a_s3, v_b_s3;
	out_t               out_q;
	logic               rdy_o, rdy3, rdy2, rdy1;

	// scaled value limited to [clamp_min, clamp_max] in q24, lower bound applied last
	function automatic logic signed [31:0] clamp_q24(
		input logic signed [63:0] p,
		input logic signed [7:0]  cmin,
		input logic signed [7:0]  cmax
	);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		logic signed [63:0] v;
		hi = {{32{cmax[7]}}, cmax, 24'b0};
		lo = {{32{cmin[7]}}, cmin, 24'b0};
		v  = p;
		if (v > hi) begin
			v = hi;
		end
		if (v < lo) begin
			v = lo;
		end
		return v[31:0];
	endfunction

	// half away from zero, then offset; clamped input keeps it inside 0..255
	function automatic logic signed [31:0] round_offset(input logic signed [31:0] v);
		logic signed [32:0] ve;
		logic [32:0]        mag;
		logic [32:0]        rnd;
		logic signed [9:0]  r;
		logic signed [9:0]  res;
		ve  = {v[31], v};
		mag = ve[32] ? 33'(-ve) : 33'(ve);
		rnd = (mag + 33'd8388608) >> 24;
		r   = ve[32] ? -$signed({1'b0, rnd[8:0]}) : $signed({1'b0, rnd[8:0]});
		res = r + 10'sd128;
		return {{22{res[9]}}, res};
	endfunction

	assign rdy_o = !valid_q || !out_stall;
	assign rdy3  = !valid_s3 || rdy_o;
	assign rdy2  = !valid_s2 || rdy3;
	assign rdy1  = !valid_s1 || rdy2;
	assign pop   = q_valid && rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (rdy1) begin
				valid_s1 <= q_valid;
			end
			if (rdy2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy3) begin
				valid_s3 <= valid_s2;
			end
			if (rdy_o) begin
				valid_q <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			d_a_s1     <= job.sum_a + job.bias;
			d_b_s1     <= job.sum_b + job.bias;
			scale_s1   <= job.scale;
			two_col_s1 <= job.two_col;
		end
		if (rdy2) begin
			p_a_s2     <= d_a_s1 * scale_s1;
			p_b_s2     <= d_b_s1 * scale_s1;
			d_a_s2     <= d_a_s1;
			d_b_s2     <= d_b_s1;
			two_col_s2 <= two_col_s1;
		end
		if (rdy3) begin
			v_a_s3     <= cfg.quantize_output ?
				clamp_q24(p_a_s2, cfg.clamp_min, cfg.clamp_max) : d_a_s2;
			v_b_s3     <= cfg.quantize_output ?
				clamp_q24(p_b_s2, cfg.clamp_min, cfg.clamp_max) : d_b_s2;
			two_col_s3 <= two_col_s2;
		end
		if (rdy_o) begin
			out_q.result_a <= cfg.quantize_output ? round_offset(v_a_s3) : v_a_s3;
			if (two_col_s3) begin
				out_q.result_b <= cfg.quantize_output ? round_offset(v_b_s3) : v_b_s3;
			end else begin
				out_q.result_b <= '0;
			end
		end
	end

	assign out_valid = valid_q;
	assign out_data  = out_q;

endmodule
